/* rtl/gf1r_pkg.sv */
// ============================================================================
// gf1r_pkg
// Shared types and constants of the mirrored-edge 1-D Gaussian row filter.
// ============================================================================
package gf1r_pkg;

    // Fixed field widths
    localparam int POS_BITS       = 16;
    localparam int RADIUS_BITS    = 4;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int COEF_SLOT_BITS = 16;
    localparam int COEF_PER_PACK  = 4;
    localparam int NUM_PACKS      = 4;
    localparam int NUM_COEF       = COEF_PER_PACK * NUM_PACKS;
    localparam int COEF_IDX_BITS  = RADIUS_BITS;

    // Configuration register map
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROW_LENGTH  = 3'd0,
        REG_RADIUS      = 3'd1,
        REG_COEF_PACK_0 = 3'd2,
        REG_COEF_PACK_1 = 3'd3,
        REG_COEF_PACK_2 = 3'd4,
        REG_COEF_PACK_3 = 3'd5
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ERR,
        ST_TAP,
        ST_DRAIN
    } t_seq_state;

    typedef logic [COEF_SLOT_BITS-1:0] t_coef_slot;

    // One tap-pair issued to the MAC pipe
    typedef struct packed {
        logic                     vld;
        logic                     first;
        logic                     last;
        logic [COEF_IDX_BITS-1:0] idx;
    } t_tap;

    // Result request from the sequencer to the output register
    typedef struct packed {
        logic vld;
        logic err;
        logic done;
    } t_res_req;

endpackage

/* rtl/gf1r_if.sv */
// ============================================================================
// gf1r channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ============================================================================
interface gf1r_sample_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface gf1r_result_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered_value;
    logic                          row_done;
    logic                          size_error;

    modport source (output valid, output filtered_value, output row_done,
                    output size_error, input ready);
    modport sink   (input valid, input filtered_value, input row_done,
                    input size_error, output ready);
endinterface

interface gf1r_cfg_if import gf1r_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/gf1r_ram.sv */
// ============================================================================
// gf1r_ram
// Sample store: one write port, two read ports with registered read data.
// ============================================================================
module gf1r_ram #(
    parameter int DATA_BITS = 16,
    parameter int ADDR_BITS = 5
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic [ADDR_BITS-1:0] i_rd_addr_a,
    input  logic [ADDR_BITS-1:0] i_rd_addr_b,
    output logic [DATA_BITS-1:0] o_rd_data_a,
    output logic [DATA_BITS-1:0] o_rd_data_b
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rd_data_a;
    logic [DATA_BITS-1:0] r_rd_data_b;

    // Write the newest sample
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read both taps of a pair
    always_ff @(posedge i_clk) begin
        r_rd_data_a <= r_mem[i_rd_addr_a];
        r_rd_data_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

/* rtl/gf1r_seq.sv */
// ============================================================================
// gf1r_seq
// Row sequencer: tracks the row position, writes samples to the store,
// walks the outputs due for each sample and issues mirrored tap-pair reads.
// ============================================================================
module gf1r_seq import gf1r_pkg::*; #(
    parameter int MAX_RADIUS = 15,
    parameter int ADDR_BITS  = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [POS_BITS-1:0]    i_row_length,
    input  logic [RADIUS_BITS-1:0] i_radius,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_mac_done,
    input  logic                   i_take,
    output logic                   o_wr_en,
    output logic [ADDR_BITS-1:0]   o_wr_addr,
    output logic [ADDR_BITS-1:0]   o_rd_addr_a,
    output logic [ADDR_BITS-1:0]   o_rd_addr_b,
    output t_tap                   o_tap,
    output t_res_req               o_req
);

    localparam int EXT_BITS = POS_BITS + 2;
    typedef logic [EXT_BITS-1:0] t_ext;

    t_seq_state             r_state, n_state;
    logic [POS_BITS-1:0]    r_pos, n_pos;
    logic [POS_BITS-1:0]    r_j, n_j;
    logic [POS_BITS-1:0]    r_jhi, n_jhi;
    logic                   r_last, n_last;
    logic [RADIUS_BITS-1:0] r_t, n_t;

    logic [RADIUS_BITS-1:0] rad;
    logic [POS_BITS-1:0]    rad_pos;
    logic                   size_bad;
    logic [POS_BITS-1:0]    pos_eff;
    logic                   row_last;
    logic                   p_ge_r;
    logic [POS_BITS-1:0]    p_minus_r;
    logic                   j_final;

    t_ext jp, jm, wrap_hi, a_hi, a_lo;

    // Clamp the radius and check the row geometry
    assign rad       = (i_radius > RADIUS_BITS'(MAX_RADIUS)) ? RADIUS_BITS'(MAX_RADIUS)
                                                             : i_radius;
    assign rad_pos   = POS_BITS'(rad);
    assign size_bad  = (i_row_length == '0) || (rad_pos > i_row_length);
    assign pos_eff   = (r_pos >= i_row_length) ? '0 : r_pos;
    assign row_last  = (pos_eff == i_row_length - POS_BITS'(1));
    assign p_ge_r    = (pos_eff >= rad_pos);
    assign p_minus_r = pos_eff - rad_pos;
    assign j_final   = (r_j == r_jhi);

    // Mirror the upper tap at the row end and the lower tap at the row start
    always_comb begin
        jp      = t_ext'(r_j) + t_ext'(r_t);
        jm      = t_ext'(r_j) - t_ext'(r_t);
        wrap_hi = (t_ext'(i_row_length) << 1) - t_ext'(1) - jp;
        a_hi    = (jp >= t_ext'(i_row_length)) ? wrap_hi : jp;
        a_lo    = jm[EXT_BITS-1] ? ~jm : jm;
    end

    assign o_rd_addr_a = a_hi[ADDR_BITS-1:0];
    assign o_rd_addr_b = a_lo[ADDR_BITS-1:0];
    assign o_wr_addr   = pos_eff[ADDR_BITS-1:0];
    assign o_in_ready  = (r_state == ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    // Output walk registers
    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_jhi  <= n_jhi;
        r_last <= n_last;
        r_t    <= n_t;
    end

    // Next state and outputs
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_j     = r_j;
        n_jhi   = r_jhi;
        n_last  = r_last;
        n_t     = r_t;
        o_wr_en = 1'b0;
        o_tap   = '0;
        o_req   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (size_bad) begin
                        // drop the sample and restart the row
                        n_pos   = '0;
                        n_state = ST_ERR;
                    end else begin
                        o_wr_en = 1'b1;
                        n_pos   = row_last ? '0 : pos_eff + POS_BITS'(1);
                        n_j     = p_ge_r ? p_minus_r : '0;
                        n_jhi   = row_last ? i_row_length - POS_BITS'(1) : p_minus_r;
                        n_last  = row_last;
                        n_t     = '0;
                        if (row_last || p_ge_r) begin
                            n_state = ST_TAP;
                        end
                    end
                end
            end
            ST_ERR: begin
                o_req.vld = 1'b1;
                o_req.err = 1'b1;
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TAP: begin
                // issue one tap pair per cycle
                o_tap.vld   = 1'b1;
                o_tap.first = (r_t == '0);
                o_tap.last  = (r_t == rad);
                o_tap.idx   = r_t;
                if (r_t == rad) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_t = r_t + RADIUS_BITS'(1);
                end
            end
            ST_DRAIN: begin
                // wait for the pipe, then advance to the next output
                o_req.vld  = i_mac_done;
                o_req.done = r_last && j_final;
                if (i_take) begin
                    if (j_final) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j     = r_j + POS_BITS'(1);
                        n_t     = '0;
                        n_state = ST_TAP;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/gf1r_mac.sv */
// ============================================================================
// gf1r_mac
// Folded multiply-accumulate pipe: pair add, coefficient multiply,
// accumulate, round half away from zero, saturate.
// ============================================================================
module gf1r_mac import gf1r_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tap                   i_tap,
    input  logic [SAMPLE_BITS-1:0] i_rd_data_a,
    input  logic [SAMPLE_BITS-1:0] i_rd_data_b,
    input  t_coef_slot             i_coef [NUM_COEF],
    input  logic                   i_take,
    output logic                   o_done,
    output logic [SAMPLE_BITS-1:0] o_value
);

    localparam int PAIR_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS + 2;
    localparam int ACC_BITS  = SAMPLE_BITS + COEF_BITS + 6;
    localparam int RND_BITS  = ACC_BITS - COEF_BITS;
    localparam int TOP_BITS  = RND_BITS - SAMPLE_BITS + 1;
    localparam logic [ACC_BITS-1:0] HALF    = ACC_BITS'(1) << (COEF_BITS - 1);
    localparam logic [ACC_BITS-1:0] HALF_M1 = HALF - ACC_BITS'(1);

    t_tap                        r_tap1, r_tap2, r_tap3, r_tap4;
    logic signed [PAIR_BITS-1:0] r_pair;
    logic [COEF_BITS-1:0]        r_coef;
    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [RND_BITS-1:0]  r_rnd;
    logic                        r_done;

    logic signed [COEF_BITS:0]   coef_ext;
    logic [ACC_BITS-1:0]         prod_ext;
    logic [ACC_BITS-1:0]         acc_base;
    logic [ACC_BITS-1:0]         rnd_sum;
    logic [TOP_BITS-1:0]         top_bits;
    logic                        fits;

    // Tag pipe, aligned with the registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap1 <= '0;
            r_tap2 <= '0;
            r_tap3 <= '0;
            r_tap4 <= '0;
        end else begin
            r_tap1 <= i_tap;
            r_tap2 <= r_tap1;
            r_tap3 <= r_tap2;
            r_tap4 <= r_tap3;
        end
    end

    // Fold the pair; the center tap counts once
    always_ff @(posedge i_clk) begin
        if (r_tap1.first) begin
            r_pair <= {i_rd_data_a[SAMPLE_BITS-1], i_rd_data_a};
        end else begin
            r_pair <= {i_rd_data_a[SAMPLE_BITS-1], i_rd_data_a}
                    + {i_rd_data_b[SAMPLE_BITS-1], i_rd_data_b};
        end
        r_coef <= i_coef[r_tap1.idx][COEF_BITS-1:0];
    end

    // Multiply by the unsigned coefficient
    assign coef_ext = {1'b0, r_coef};

    always_ff @(posedge i_clk) begin
        r_prod <= r_pair * coef_ext;
    end

    // Accumulate, restarting on the first pair of an output
    assign prod_ext = {{(ACC_BITS - PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod};
    assign acc_base = r_tap3.first ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (r_tap3.vld) begin
            r_acc <= acc_base + prod_ext;
        end
    end

    // Round half away from zero at the coefficient fraction point
    assign rnd_sum = r_acc + (r_acc[ACC_BITS-1] ? HALF_M1 : HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (r_tap4.vld && r_tap4.last) begin
            r_done <= 1'b1;
        end else if (i_take) begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tap4.vld && r_tap4.last) begin
            r_rnd <= rnd_sum[ACC_BITS-1:COEF_BITS];
        end
    end

    // Saturate to the sample width
    assign top_bits = r_rnd[RND_BITS-1:SAMPLE_BITS-1];
    assign fits     = (&top_bits) || !(|top_bits);

    always_comb begin
        if (fits) begin
            o_value = r_rnd[SAMPLE_BITS-1:0];
        end else if (r_rnd[RND_BITS-1]) begin
            o_value = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        end else begin
            o_value = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end
    end

    assign o_done = r_done;

endmodule

/* rtl/gaussian_filter_1d_reflect.sv */
// ============================================================================
// gaussian_filter_1d_reflect
// Streaming 1-D Gaussian filter over rows with mirrored edges.
// ============================================================================
// Usage:
//   i_cfg  : register writes (row length, radius, four coefficient packs),
//            always ready; write only while the filter is idle.
//   i_in   : one signed sample per transfer, row after row.
//   o_out  : filtered samples; row_done marks the last output of a row,
//            size_error marks a zero result for an empty row or a radius longer than the row.
// Flow:
//   Output j is computed once sample j+r has been taken; each output runs
//   its tap pairs, from the center out to offset r, through the shared
//   multiplier, then the read, pair, product, accumulate and round registers.
//   The last sample of a row produces up to r+1 results back to back in this
//   way. A sample with no output due leaves the input ready; a size error
//   result holds the input until the result is taken.
//   The input stays not ready while results of the current sample are being
//   computed; the single port of the multiply-accumulate pipe sets the rate.
// Reset clears the row position and the output valid flag; the sample store
//   needs no clearing since only samples of the current row are read.
// A stalled receiver holds the result register; computation of the next
//   result finishes and waits until the register is free.
// ============================================================================
module gaussian_filter_1d_reflect import gf1r_pkg::*; #(
    parameter int MAX_RADIUS  = 15,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gf1r_cfg_if.sink        i_cfg,
    gf1r_sample_if.sink     i_in,
    gf1r_result_if.source   o_out
);

    localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int ADDR_BITS = $clog2(WIN_DEPTH);

    logic [POS_BITS-1:0]      r_row_length;
    logic [RADIUS_BITS-1:0]   r_radius;
    logic [CFG_DATA_BITS-1:0] r_coef_pack [NUM_PACKS];
    t_coef_slot               coef [NUM_COEF];

    logic                   wr_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [ADDR_BITS-1:0]   rd_addr_a;
    logic [ADDR_BITS-1:0]   rd_addr_b;
    logic [SAMPLE_BITS-1:0] rd_data_a;
    logic [SAMPLE_BITS-1:0] rd_data_b;
    t_tap                   tap;
    t_res_req               req;
    logic                   mac_done;
    logic [SAMPLE_BITS-1:0] mac_value;
    logic                   out_free;
    logic                   take;

    logic                   r_out_vld;
    logic [SAMPLE_BITS-1:0] r_out_value;
    logic                   r_out_done;
    logic                   r_out_err;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= POS_BITS'(1);
            r_radius     <= '0;
            for (int k = 0; k < NUM_PACKS; k++) begin
                r_coef_pack[k] <= '0;
            end
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_ROW_LENGTH:  r_row_length   <= i_cfg.data[POS_BITS-1:0];
                REG_RADIUS:      r_radius       <= i_cfg.data[RADIUS_BITS-1:0];
                REG_COEF_PACK_0: r_coef_pack[0] <= i_cfg.data;
                REG_COEF_PACK_1: r_coef_pack[1] <= i_cfg.data;
                REG_COEF_PACK_2: r_coef_pack[2] <= i_cfg.data;
                REG_COEF_PACK_3: r_coef_pack[3] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Split the packs into one slot per tap offset
    always_comb begin
        for (int k = 0; k < NUM_PACKS; k++) begin
            for (int m = 0; m < COEF_PER_PACK; m++) begin
                coef[k * COEF_PER_PACK + m] = r_coef_pack[k][m * COEF_SLOT_BITS +: COEF_SLOT_BITS];
            end
        end
    end

    gf1r_seq #(
        .MAX_RADIUS (MAX_RADIUS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_row_length (r_row_length),
        .i_radius     (r_radius),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (i_in.ready),
        .i_mac_done   (mac_done),
        .i_take       (take),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_rd_addr_a  (rd_addr_a),
        .o_rd_addr_b  (rd_addr_b),
        .o_tap        (tap),
        .o_req        (req)
    );

    gf1r_ram #(
        .DATA_BITS (SAMPLE_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_in.sample),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    gf1r_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tap       (tap),
        .i_rd_data_a (rd_data_a),
        .i_rd_data_b (rd_data_b),
        .i_coef      (coef),
        .i_take      (take),
        .o_done      (mac_done),
        .o_value     (mac_value)
    );

    // Output register: load when empty or being drained
    assign out_free = !r_out_vld || o_out.ready;
    assign take     = req.vld && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (take) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_value <= req.err ? '0 : mac_value;
            r_out_done  <= req.done;
            r_out_err   <= req.err;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.filtered_value = r_out_value;
    assign o_out.row_done       = r_out_done;
    assign o_out.size_error     = r_out_err;

endmodule

/* rtl/gf1r_checker.sv */
// ============================================================================
// gf1r_checker
// Port-level checks of the Gaussian row filter, bound to the top level.
// ============================================================================
module gf1r_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_out_value,
    input logic                   i_out_done,
    input logic                   i_out_err
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_done)
            && $stable(i_out_err))
        else $error("stalled result changed");

    // Size errors carry a zero value and never close a row
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err |-> (i_out_value == '0) && !i_out_done)
        else $error("size error result with nonzero value or row end");

    // A fresh size error result follows a sample transfer, through the error state and then the output register
    a_err_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) && i_out_err |-> $past(i_in_valid && i_in_ready, 2))
        else $error("size error result without a sample transfer");

endmodule

bind gaussian_filter_1d_reflect gf1r_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_gf1r_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.filtered_value),
    .i_out_done  (o_out.row_done),
    .i_out_err   (o_out.size_error)
);
